[hw/rtl/tpcd_pkg.sv]
// ----------------------------------------------------------------------------
// tpcd_pkg
// Shared constants and types for the touch pad calibrate/detect block.
// ----------------------------------------------------------------------------
package tpcd_pkg;

  // calibration window length, a power of two
  localparam int CAL_SAMPLES = 64;
  localparam int PAD_COUNT   = 4;

  localparam int SAMPLE_W  = 16;
  localparam int PAD_W     = 2;
  localparam int BMAP_W    = 4;
  localparam int CAL_SHIFT = $clog2(CAL_SAMPLES);
  localparam int CNT_W     = (CAL_SHIFT > 0) ? CAL_SHIFT : 1;
  localparam int SUM_W     = SAMPLE_W + CAL_SHIFT;
  localparam int PAD_IDX_W = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
  localparam int TB_W      = (PAD_COUNT > BMAP_W) ? PAD_COUNT : BMAP_W;

  localparam logic CMD_CAL = 1'b0;
  localparam logic CMD_DET = 1'b1;

  typedef struct packed {
    logic                en;
    logic                command;
    logic [PAD_W-1:0]    pad;
    logic [SAMPLE_W-1:0] sample;
  } tpcd_req_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] threshold;
    logic                calibration_done;
    logic [BMAP_W-1:0]   button_map;
    logic                touched;
  } tpcd_res_t;

endpackage

[hw/rtl/tpcd_pad_core.sv]
// ----------------------------------------------------------------------------
// tpcd_pad_core
// Per-pad calibration state, threshold computation and touch detection.
// ----------------------------------------------------------------------------
module tpcd_pad_core
  import tpcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  tpcd_req_t req,
  output tpcd_res_t res
);

  logic [SUM_W-1:0]    sum_r [PAD_COUNT];
  logic [CNT_W-1:0]    cnt_r [PAD_COUNT];
  logic [SAMPLE_W-1:0] thr_r [PAD_COUNT];
  logic [PAD_COUNT-1:0] touch_r;
  logic [PAD_COUNT-1:0] touch_nxt;

  logic [PAD_IDX_W-1:0] idx;
  logic                 pad_ok;
  logic [CNT_W-1:0]     cur_cnt;
  logic                 first;
  logic                 last;
  logic [SUM_W-1:0]     sum_nxt;
  logic [SAMPLE_W-1:0]  max_base;
  logic [SAMPLE_W-1:0]  max_nxt;
  logic [SAMPLE_W-1:0]  base;
  logic [SAMPLE_W-1:0]  base_c;
  logic [SAMPLE_W:0]    thr_sum;
  logic [SAMPLE_W-1:0]  thr_fin;
  logic [SAMPLE_W-1:0]  thr_cal;
  logic [CNT_W-1:0]     cnt_nxt;
  logic                 hit;
  logic [TB_W-1:0]      touch_ext;
  logic                 cal_wr;
  logic                 det_wr;

  assign idx     = PAD_IDX_W'(req.pad);
  assign pad_ok  = (32'(req.pad) < PAD_COUNT);
  assign cur_cnt = cnt_r[idx];
  assign first   = (cur_cnt == '0);
  assign last    = (cur_cnt == CNT_W'(CAL_SAMPLES - 1));

  // window start clears the running sum and maximum
  assign sum_nxt  = (first ? '0 : sum_r[idx]) + SUM_W'(req.sample);
  assign max_base = first ? '0 : thr_r[idx];
  assign max_nxt  = (req.sample > max_base) ? req.sample : max_base;

  assign base    = SAMPLE_W'(sum_nxt >> CAL_SHIFT);
  assign base_c  = (base > max_nxt) ? max_nxt : base;
  assign thr_sum = {1'b0, max_nxt} + (SAMPLE_W + 1)'((max_nxt - base_c) >> 1);
  assign thr_fin = thr_sum[SAMPLE_W] ? '1 : thr_sum[SAMPLE_W-1:0];
  assign thr_cal = last ? thr_fin : max_nxt;
  assign cnt_nxt = last ? '0 : cur_cnt + CNT_W'(1);

  assign hit = (req.sample > thr_r[idx]);

  assign cal_wr = req.en && pad_ok && (req.command == CMD_CAL);
  assign det_wr = req.en && pad_ok && (req.command == CMD_DET);

  always_comb begin
    touch_nxt = touch_r;
    if (pad_ok && (req.command == CMD_DET)) begin
      touch_nxt[idx] = hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PAD_COUNT; i++) begin
        sum_r[i] <= '0;
        cnt_r[i] <= '0;
        thr_r[i] <= '0;
      end
      touch_r <= '0;
    end else begin
      if (cal_wr) begin
        sum_r[idx] <= sum_nxt;
        cnt_r[idx] <= cnt_nxt;
        thr_r[idx] <= thr_cal;
      end
      if (det_wr) begin
        touch_r <= touch_nxt;
      end
    end
  end

  assign touch_ext = TB_W'(touch_nxt);

  always_comb begin
    res                  = '0;
    res.button_map       = touch_ext[BMAP_W-1:0];
    if (pad_ok) begin
      if (req.command == CMD_CAL) begin
        res.calibration_done = last;
        res.threshold        = thr_cal;
      end else begin
        res.touched   = hit;
        res.threshold = thr_r[idx];
      end
    end
  end

endmodule

[hw/rtl/touch_pad_calibrate_detect.sv]
// ----------------------------------------------------------------------------
// touch_pad_calibrate_detect
// Four-pad capacitive touch calibration and detection, stream interface.
// ----------------------------------------------------------------------------
// Takes one item per clock while in_tready is high and returns one result
// item per input item via an input register, then a result register.
// Throughput is one item per cycle with out_tready held high; all per-pad state
// updates in the same cycle the item leaves the input register, so consecutive
// items for the same pad see each other's effects with no bubbles. A calibration
// window is 64 samples per pad; thresholds are zero after reset.
module touch_pad_calibrate_detect
  import tpcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  input  logic [2:0]  in_tuser,   // [0] command, [2:1] pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [0] touched, [4:1] button_map,
                                  // [5] calibration_done, [21:6] threshold
);

  logic                s1_valid_r;
  logic                s1_cmd_r;
  logic [PAD_W-1:0]    s1_pad_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic                out_valid_r;
  tpcd_res_t           out_res_r;
  logic                adv;
  tpcd_req_t           req;
  tpcd_res_t           res;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r    <= in_tuser[0];
      s1_pad_r    <= in_tuser[2:1];
      s1_sample_r <= in_tdata[SAMPLE_W-1:0];
    end
  end

  assign req.en      = s1_valid_r && adv;
  assign req.command = s1_cmd_r;
  assign req.pad     = s1_pad_r;
  assign req.sample  = s1_sample_r;

  tpcd_pad_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.threshold, out_res_r.calibration_done,
                       out_res_r.button_map, out_res_r.touched};

endmodule
